// ===== design/bertlv_pkg.sv =====
// Shared types and constants of the BER TLV stream decoder.
// No dependencies; the front end, back end and top level refer to it by scoped names.
package bertlv_pkg;

  // Default number of long-form length bytes accepted
  localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Low five bits of the first identifier octet: all ones means long tag
  localparam logic [7:0] TAG_NUM_MASK = 8'h1F;

  typedef enum logic [2:0] {
    EV_HDR_BYTE = 3'd0,
    EV_HDR_DONE = 3'd1,
    EV_VALUE    = 3'd2,
    EV_END      = 3'd3,
    EV_ERROR    = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TAG_TRUNC   = 3'd1,
    ERR_TAG_OVFL    = 3'd2,
    ERR_LEN_MISSING = 3'd3,
    ERR_LEN_LARGE   = 3'd4,
    ERR_LEN_TRUNC   = 3'd5,
    ERR_VALUE_TRUNC = 3'd6
  } error_e;

  // One classified stream transaction as it sits in the queue
  typedef struct packed {
    logic       at_end;     // end-of-stream marker
    logic [7:0] data;       // raw stream byte
    logic       tag_long;   // first tag byte would open a long tag
    logic       n_zero;     // length count field is zero (indefinite)
    logic       n_too_big;  // length count field exceeds the limit
  } item_t;

endpackage

// ===== design/bertlv_in_if.sv =====
// Input channel of the BER TLV decoder: valid/ready plus operation flag and stream byte.
// No dependencies.
interface bertlv_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ===== design/bertlv_out_if.sv =====
// Output channel of the BER TLV decoder: valid/ready plus event payload.
// No dependencies.
interface bertlv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [2:0]  error_code;
  logic [2:0]  class_bits;
  logic [30:0] tag_num;
  logic [31:0] value_length;
  logic [3:0]  header_size;
  logic [7:0]  value_byte;
  logic        last_value;

  modport source (output valid, output event_res, output error_code, output class_bits,
                  output tag_num, output value_length, output header_size,
                  output value_byte, output last_value, input ready);
  modport sink   (input valid, input event_res, input error_code, input class_bits,
                  input tag_num, input value_length, input header_size,
                  input value_byte, input last_value, output ready);
endinterface

// ===== design/bertlv_front.sv =====
// Front end: accepts stream transactions, classifies each byte and queues it.
// Depends on bertlv_pkg and bertlv_in_if.
module bertlv_front #(
  parameter int unsigned MaxLengthBytes = bertlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bertlv_in_if.sink           in_i,
  output bertlv_pkg::item_t   item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);

  localparam int unsigned PtrW = $clog2(bertlv_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] Depth = CntW'(bertlv_pkg::QUEUE_DEPTH);

  bertlv_pkg::item_t          queue_q [bertlv_pkg::QUEUE_DEPTH];
  bertlv_pkg::item_t          item_new;
  logic [PtrW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]            count_q, count_d;
  logic                       push, pop;

  // Classify the incoming byte
  always_comb begin
    item_new.at_end    = in_i.operation;
    item_new.data      = in_i.data_byte;
    item_new.tag_long  = (in_i.data_byte & bertlv_pkg::TAG_NUM_MASK) ==
                         bertlv_pkg::TAG_NUM_MASK;
    item_new.n_zero    = (in_i.data_byte[6:0] == 7'd0);
    item_new.n_too_big = (32'(in_i.data_byte[6:0]) > 32'(MaxLengthBytes));
  end

  assign in_i.ready   = (count_q != Depth);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

  // Fill level never passes the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Depth)
    else $error("queue count exceeds depth");

  // The count rises by one after a push without a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not follow a push");

endmodule

// ===== design/bertlv_back.sv =====
// Back end: BER header parser and value pass-through with output register.
// Depends on bertlv_pkg and bertlv_out_if.
module bertlv_back #(
  parameter int unsigned MaxLengthBytes = bertlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bertlv_pkg::item_t   item_i,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  bertlv_out_if.source        out_o
);

  localparam int unsigned LeftW = $clog2(MaxLengthBytes + 1);

  typedef enum logic [5:0] {
    PH_TAG_FIRST = 6'b000001,
    PH_TAG_LONG  = 6'b000010,
    PH_LEN_FIRST = 6'b000100,
    PH_LEN_LONG  = 6'b001000,
    PH_VALUE     = 6'b010000,
    PH_FAILED    = 6'b100000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [2:0]           class_q, class_d;
  logic [30:0]          tag_q, tag_d;
  logic [3:0]           hcount_q, hcount_d;
  logic [31:0]          length_q, length_d;
  logic [LeftW-1:0]     left_q, left_d;
  logic [31:0]          vleft_q, vleft_d;
  logic                 suppress_q, suppress_d;
  bertlv_pkg::error_e   sticky_q, sticky_d;

  logic                 out_valid_q, out_valid_d;
  bertlv_pkg::event_e   ev_q, ev;
  logic [7:0]           vbyte_q, vbyte;
  logic                 last_q, last;
  logic                 emit;

  // A transaction is taken when the output register is free or draining
  assign item_pop_o = item_valid_i && (!out_valid_q || out_o.ready);

  // Parser step
  always_comb begin
    logic [3:0]       hcount_inc;
    logic [LeftW-1:0] left_next;
    logic [31:0]      vleft_next;
    logic             hdr_done;
    logic             eoc;
    logic [7:0]       b;

    b          = item_i.data;
    hcount_inc = (hcount_q != 4'hF) ? hcount_q + 4'd1 : hcount_q;
    left_next  = (left_q != '0) ? left_q - LeftW'(1) : left_q;
    vleft_next = (vleft_q != '0) ? vleft_q - 32'd1 : vleft_q;
    hdr_done   = 1'b0;
    eoc        = 1'b0;

    phase_d    = phase_q;
    class_d    = class_q;
    tag_d      = tag_q;
    hcount_d   = hcount_q;
    length_d   = length_q;
    left_d     = left_q;
    vleft_d    = vleft_q;
    suppress_d = suppress_q;
    sticky_d   = sticky_q;
    emit       = 1'b0;
    ev         = bertlv_pkg::EV_HDR_BYTE;
    vbyte      = 8'd0;
    last       = 1'b0;

    if (item_pop_o) begin
      if (phase_q == PH_FAILED) begin
        emit = 1'b1;
        ev   = bertlv_pkg::EV_ERROR;
      end else if (item_i.at_end) begin
        emit    = 1'b1;
        ev      = bertlv_pkg::EV_ERROR;
        phase_d = PH_FAILED;
        unique case (phase_q)
          PH_TAG_FIRST: begin
            ev      = bertlv_pkg::EV_END;
            phase_d = phase_q;
          end
          PH_TAG_LONG:  sticky_d = bertlv_pkg::ERR_TAG_TRUNC;
          PH_LEN_FIRST: sticky_d = bertlv_pkg::ERR_LEN_MISSING;
          PH_LEN_LONG:  sticky_d = bertlv_pkg::ERR_LEN_TRUNC;
          default:      sticky_d = bertlv_pkg::ERR_VALUE_TRUNC;
        endcase
      end else begin
        unique case (phase_q)
          PH_TAG_FIRST: begin
            emit       = 1'b1;
            class_d    = b[7:5];
            hcount_d   = 4'd1;
            length_d   = '0;
            left_d     = '0;
            vleft_d    = '0;
            suppress_d = 1'b0;
            if (item_i.tag_long) begin
              tag_d   = '0;
              phase_d = PH_TAG_LONG;
            end else begin
              tag_d   = {26'd0, b[4:0]};
              phase_d = PH_LEN_FIRST;
            end
          end
          PH_TAG_LONG: begin
            emit = 1'b1;
            if (tag_q[30:24] != 7'd0) begin
              ev       = bertlv_pkg::EV_ERROR;
              sticky_d = bertlv_pkg::ERR_TAG_OVFL;
              phase_d  = PH_FAILED;
            end else begin
              hcount_d = hcount_inc;
              tag_d    = {tag_q[23:0], b[6:0]};
              if (!b[7]) begin
                phase_d = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            hcount_d = hcount_inc;
            if (!b[7]) begin
              length_d = {24'd0, b};
              hdr_done = 1'b1;
            end else if (item_i.n_zero) begin
              emit     = 1'b1;
              ev       = bertlv_pkg::EV_ERROR;
              sticky_d = bertlv_pkg::ERR_VALUE_TRUNC;
              phase_d  = PH_FAILED;
            end else if (item_i.n_too_big) begin
              emit     = 1'b1;
              ev       = bertlv_pkg::EV_ERROR;
              sticky_d = bertlv_pkg::ERR_LEN_LARGE;
              phase_d  = PH_FAILED;
            end else begin
              emit     = 1'b1;
              length_d = '0;
              left_d   = b[LeftW-1:0];
              phase_d  = PH_LEN_LONG;
            end
          end
          PH_LEN_LONG: begin
            if (length_q[31:24] != 8'd0) begin
              emit     = 1'b1;
              ev       = bertlv_pkg::EV_ERROR;
              sticky_d = bertlv_pkg::ERR_LEN_LARGE;
              phase_d  = PH_FAILED;
            end else begin
              hcount_d = hcount_inc;
              length_d = {length_q[23:0], b};
              left_d   = left_next;
              if (left_next == '0) begin
                hdr_done = 1'b1;
              end else begin
                emit = 1'b1;
              end
            end
          end
          PH_VALUE: begin
            vleft_d = vleft_next;
            if (vleft_next == '0) begin
              phase_d = PH_TAG_FIRST;
            end
            if (!suppress_q) begin
              emit  = 1'b1;
              ev    = bertlv_pkg::EV_VALUE;
              vbyte = b;
              last  = (vleft_next == '0);
            end
          end
          default: begin
            // unreachable phase code: treat as value truncation
            emit     = 1'b1;
            ev       = bertlv_pkg::EV_ERROR;
            sticky_d = bertlv_pkg::ERR_VALUE_TRUNC;
            phase_d  = PH_FAILED;
          end
        endcase

        // Header complete: an end-of-contents object reports a header byte event and its content stays silent
        if (hdr_done) begin
          eoc        = (class_q == 3'd0) && (tag_q == '0);
          emit       = 1'b1;
          suppress_d = eoc;
          vleft_d    = length_d;
          phase_d    = (length_d == '0) ? PH_TAG_FIRST : PH_VALUE;
          ev         = eoc ? bertlv_pkg::EV_HDR_BYTE : bertlv_pkg::EV_HDR_DONE;
          last       = !eoc && (length_d == '0);
        end
      end
    end

    out_valid_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG_FIRST;
      class_q     <= '0;
      tag_q       <= '0;
      hcount_q    <= '0;
      length_q    <= '0;
      left_q      <= '0;
      vleft_q     <= '0;
      suppress_q  <= 1'b0;
      sticky_q    <= bertlv_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      class_q     <= class_d;
      tag_q       <= tag_d;
      hcount_q    <= hcount_d;
      length_q    <= length_d;
      left_q      <= left_d;
      vleft_q     <= vleft_d;
      suppress_q  <= suppress_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Event-only output fields; object fields come from the next parser state
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_q    <= ev;
      vbyte_q <= vbyte;
      last_q  <= last;
    end
  end

  logic [2:0]  o_err_q, o_class_q;
  logic [30:0] o_tag_q;
  logic [31:0] o_len_q;
  logic [3:0]  o_hsize_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_err_q   <= sticky_d;
      o_class_q <= class_d;
      o_tag_q   <= tag_d;
      o_len_q   <= length_d;
      o_hsize_q <= hcount_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = ev_q;
  assign out_o.error_code   = o_err_q;
  assign out_o.class_bits   = o_class_q;
  assign out_o.tag_num      = o_tag_q;
  assign out_o.value_length = o_len_q;
  assign out_o.header_size  = o_hsize_q;
  assign out_o.value_byte   = vbyte_q;
  assign out_o.last_value   = last_q;

  // The failed phase is only left through reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == PH_FAILED) |=> (phase_q == PH_FAILED))
    else $error("decoder left the failed phase");

  // A sticky error code exists exactly while failed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (sticky_q != bertlv_pkg::ERR_NONE) == (phase_q == PH_FAILED))
    else $error("sticky error and phase disagree");

  // An error event always carries a nonzero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && ev_q == bertlv_pkg::EV_ERROR) |->
                   (o_err_q != bertlv_pkg::ERR_NONE))
    else $error("error event without error code");

  // Content of an end-of-contents object never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (item_pop_o && !item_i.at_end && phase_q == PH_VALUE && suppress_q)
                   |-> !emit)
    else $error("suppressed content byte produced a result");

endmodule

// ===== design/ber_tlv_stream_decoder.sv =====
// Top level of the BER TLV stream decoder: front end, queue and parser.
// Depends on bertlv_pkg, bertlv_in_if, bertlv_out_if, bertlv_front, bertlv_back.
//
// Usage:
//   in_i carries one stream transaction per handshake: operation = 0 with a
//   data_byte, or operation = 1 for end of stream. out_o returns exactly one
//   event per transaction (header byte, header complete, value byte, clean
//   end, error), except content bytes of end-of-contents objects, which are
//   dropped silently.
//   An accepted transaction is written into the front queue, then the parser
//   step registers its result in the output register that drives out_o.
//   Throughput: one byte per cycle while out_o.ready stays high; the front
//   queue holds four transactions.
//   Reset: rst_ni clears the queue, the parser phase and the sticky error;
//   the first byte after reset starts a new object.
//   Stall: when out_o.ready is low the result stays in the output register,
//   the parser halts and the queue fills; in_i.ready drops once it is full.
//   Errors are sticky: every later transaction returns an error event.
module ber_tlv_stream_decoder #(
  parameter int unsigned MaxLengthBytes = bertlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bertlv_in_if.sink     in_i,
  bertlv_out_if.source  out_o
);

  bertlv_pkg::item_t item;
  logic              item_valid;
  logic              item_pop;

  // Accept, classify and queue
  bertlv_front #(
    .MaxLengthBytes (MaxLengthBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // Parse and emit events
  bertlv_back #(
    .MaxLengthBytes (MaxLengthBytes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

endmodule
